@@ src/dgvb_pkg.sv @@
// Shared constants, types and helper functions of the deformation graph vertex blend.
`default_nettype none

package dgvb_pkg;

   // Graph size and fixed point format
   localparam int NODE_COUNT     = 1024;
   localparam int FRAC_BITS      = 16;
   localparam int WEIGHT_BITS    = 16;
   localparam int WORDS_PER_NODE = 15;
   localparam int NODE_WORDS     = NODE_COUNT * WORDS_PER_NODE;

   // Field and datapath widths
   localparam int NODE_W   = 10;
   localparam int SEL_W    = 4;
   localparam int WORD_W   = 32;
   localparam int COORD_W  = 32;
   localparam int WEIGHT_W = 17;
   localparam int ADDR_W   = $clog2(NODE_WORDS);
   localparam int DIFF_W   = COORD_W + 1;
   localparam int PROD_W   = 2 * DIFF_W;
   localparam int SUM_W    = 64;

   // Item actions
   localparam logic ACT_LOAD  = 1'b0;
   localparam logic ACT_BLEND = 1'b1;

   // Node word layout
   localparam logic [SEL_W-1:0] WORD_CENTER = 4'd0;
   localparam logic [SEL_W-1:0] WORD_ROT    = 4'd3;
   localparam logic [SEL_W-1:0] WORD_TRANS  = 4'd12;

   // Read order of one term: center, translation, then rotation
   localparam logic [3:0] STEP_TRANS = 4'd3;
   localparam logic [3:0] STEP_ROT   = 4'd6;
   localparam logic [3:0] STEP_LAST  = 4'd14;

   typedef struct packed {
      logic              clip;
      logic [COORD_W-1:0] value;
   } sat_type;

   // Clamp a 64-bit signed value to signed 32 bits
   function automatic sat_type sat32(input logic [SUM_W-1:0] x);
      logic    fits;
      sat_type r;
      fits    = (&x[SUM_W-1:COORD_W-1]) | ~(|x[SUM_W-1:COORD_W-1]);
      r.clip  = ~fits;
      r.value = fits ? x[COORD_W-1:0] :
                (x[SUM_W-1] ? {1'b1, {(COORD_W-1){1'b0}}} : {1'b0, {(COORD_W-1){1'b1}}});
      return r;
   endfunction

   // Node word fetched at a read step
   function automatic logic [SEL_W-1:0] word_of_step(input logic [3:0] step);
      logic [SEL_W-1:0] w;
      if (step < STEP_TRANS) begin
         w = WORD_CENTER + step;
      end else if (step < STEP_ROT) begin
         w = WORD_TRANS + (step - STEP_TRANS);
      end else begin
         w = WORD_ROT + (step - STEP_ROT);
      end
      return w;
   endfunction

   // Matrix row of a rotation read step
   function automatic logic [1:0] rot_row(input logic [3:0] step);
      logic [3:0] m;
      logic [1:0] r;
      m = step - STEP_ROT;
      case (m) inside
         [4'd0:4'd2]: r = 2'd0;
         [4'd3:4'd5]: r = 2'd1;
         default:     r = 2'd2;
      endcase
      return r;
   endfunction

   // Matrix column of a rotation read step
   function automatic logic [1:0] rot_col(input logic [3:0] step);
      logic [3:0] m;
      logic [1:0] c;
      m = step - STEP_ROT;
      case (m) inside
         4'd0, 4'd3, 4'd6: c = 2'd0;
         4'd1, 4'd4, 4'd7: c = 2'd1;
         default:          c = 2'd2;
      endcase
      return c;
   endfunction

endpackage

`default_nettype wire

@@ src/deformation_graph_vertex_blend.sv @@
// Deformation graph vertex blend: node table, term sequencer and shared multiplier.
//
//   channel   handshake              word
//   --------  ---------------------  --------------------------------------------
//   request   start & !busy          req_action .. req_last_term, one item
//   response  rsp_valid (strobe)     rsp_out_x/y/z, rsp_clipped, one cycle only
//
// A load word is taken and written to the node table at once; busy stays low.
// A blend term in range holds busy while it streams the fifteen node words
// through the table read port into the 33x33 multiplier and the 64-bit
// accumulator, then forms the three weight products and saturating sums.
// A last term adds a rounding state; the response strobes the cycle after.
// Synchronous reset clears the sequencer, sums and flags; the node table is
// not cleared and needs no clearing pass. The receiver cannot stall.
`default_nettype none

module deformation_graph_vertex_blend (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 start,
   output logic                                      busy,
   input  wire logic                                 req_action,
   input  wire logic [dgvb_pkg::NODE_W-1:0]          req_node_index,
   input  wire logic [dgvb_pkg::SEL_W-1:0]           req_word_select,
   input  wire logic signed [dgvb_pkg::WORD_W-1:0]   req_word_value,
   input  wire logic signed [dgvb_pkg::COORD_W-1:0]  req_vertex_x,
   input  wire logic signed [dgvb_pkg::COORD_W-1:0]  req_vertex_y,
   input  wire logic signed [dgvb_pkg::COORD_W-1:0]  req_vertex_z,
   input  wire logic [dgvb_pkg::WEIGHT_W-1:0]        req_blend_weight,
   input  wire logic                                 req_last_term,
   output logic                                      rsp_valid,
   output logic signed [dgvb_pkg::COORD_W-1:0]       rsp_out_x,
   output logic signed [dgvb_pkg::COORD_W-1:0]       rsp_out_y,
   output logic signed [dgvb_pkg::COORD_W-1:0]       rsp_out_z,
   output logic                                      rsp_clipped
);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_NODE   = 2'd1;
   localparam logic [1:0] ST_WEIGHT = 2'd2;
   localparam logic [1:0] ST_FINISH = 2'd3;

   localparam logic [4:0] NODE_LAST   = 5'd16;
   localparam logic [4:0] WEIGHT_LAST = 5'd3;

   localparam int AW = dgvb_pkg::ADDR_W;
   localparam int SW = dgvb_pkg::SUM_W;

   // Control state
   logic [1:0] state_ff, state_in;
   logic [4:0] cnt_ff, cnt_in;
   logic       clip_ff, clip_in;
   logic       rsp_valid_ff, rsp_valid_in;

   // Latched item
   logic [AW-1:0]                         base_ff, base_in;
   logic signed [dgvb_pkg::COORD_W-1:0]   vert_ff [3];
   logic signed [dgvb_pkg::COORD_W-1:0]   vert_in [3];
   logic [dgvb_pkg::WEIGHT_W-1:0]         w_ff, w_in;
   logic                                  last_ff, last_in;

   // Datapath
   logic signed [dgvb_pkg::WORD_W-1:0]    rd_data_ff;
   logic signed [dgvb_pkg::DIFF_W-1:0]    d_ff [3];
   logic signed [dgvb_pkg::DIFF_W-1:0]    d_in [3];
   logic signed [SW-1:0]                  acc_ff [3];
   logic signed [SW-1:0]                  acc_in [3];
   logic signed [SW-1:0]                  sum_ff [3];
   logic signed [SW-1:0]                  sum_in [3];
   logic signed [dgvb_pkg::PROD_W-1:0]    prod_ff, prod_in;
   logic signed [dgvb_pkg::COORD_W-1:0]   out_x_ff, out_x_in;
   logic signed [dgvb_pkg::COORD_W-1:0]   out_y_ff, out_y_in;
   logic signed [dgvb_pkg::COORD_W-1:0]   out_z_ff, out_z_in;
   logic                                  out_clip_ff, out_clip_in;

   // Node table
   logic [dgvb_pkg::WORD_W-1:0] node_mem [dgvb_pkg::NODE_WORDS];
   logic                        mem_we;
   logic [AW-1:0]               mem_addr;
   logic [AW-1:0]               wr_addr;
   logic [AW-1:0]               node_base;

   // Combinational helpers
   logic                                  accept;
   logic                                  in_range;
   logic [3:0]                            kd, kp;
   logic                                  data_vld, prod_vld;
   logic signed [dgvb_pkg::DIFF_W-1:0]    mul_a, mul_b;
   logic signed [SW-1:0]                  prod_shift;
   logic [1:0]                            acc_idx;
   logic                                  acc_we, acc_load;
   logic signed [SW-1:0]                  acc_addend;
   logic [1:0]                            sum_idx;
   logic signed [SW:0]                    sum_wide;
   dgvb_pkg::sat_type                     pos_sat;
   logic signed [SW-1:0]                  fin_shift [3];
   logic signed [SW-1:0]                  fin_round [3];
   dgvb_pkg::sat_type                     fin_sat [3];

   // Sign extension of a 32-bit word to the multiplier width
   function automatic logic signed [dgvb_pkg::DIFF_W-1:0] DIFF_WEXT(
      input logic signed [dgvb_pkg::COORD_W-1:0] x);
      return dgvb_pkg::DIFF_W'(x);
   endfunction

   assign busy      = (state_ff != ST_IDLE);
   assign accept    = start && !busy;
   assign in_range  = 32'(req_node_index) < 32'(dgvb_pkg::NODE_COUNT);
   assign node_base = AW'(req_node_index) * AW'(dgvb_pkg::WORDS_PER_NODE);
   assign wr_addr   = node_base + AW'(req_word_select);

   // Table port: loads write while idle, the sequencer reads while busy
   assign mem_we   = accept && (req_action == dgvb_pkg::ACT_LOAD) && in_range &&
                     (32'(req_word_select) < 32'(dgvb_pkg::WORDS_PER_NODE));
   assign mem_addr = busy ? base_ff + AW'(dgvb_pkg::word_of_step(cnt_ff[3:0])) : wr_addr;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         node_mem[mem_addr] <= req_word_value;
      end
      rd_data_ff <= node_mem[mem_addr];
   end

   // Pipeline positions in the node phase: table data lags by the read register, product by read and product registers
   assign kd         = 4'(cnt_ff - 5'd1);
   assign kp         = 4'(cnt_ff - 5'd2);
   assign data_vld   = (state_ff == ST_NODE) && (cnt_ff >= 5'd1) &&
                       (cnt_ff <= 5'(dgvb_pkg::STEP_LAST) + 5'd1);
   assign prod_vld   = (state_ff == ST_NODE) && (cnt_ff >= 5'd2) &&
                       (kp >= dgvb_pkg::STEP_ROT);
   assign prod_shift = 64'(prod_ff >>> dgvb_pkg::FRAC_BITS);

   // Rounding of the sums for the response
   always_comb begin
      for (int a = 0; a < 3; a++) begin
         fin_shift[a] = sum_ff[a] >>> dgvb_pkg::WEIGHT_BITS;
         fin_round[a] = fin_shift[a] + $signed(64'(sum_ff[a][dgvb_pkg::WEIGHT_BITS-1]));
         fin_sat[a]   = dgvb_pkg::sat32(fin_round[a]);
      end
   end

   // Sequencer and shared datapath
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      clip_in      = clip_ff;
      rsp_valid_in = 1'b0;
      base_in      = base_ff;
      w_in         = w_ff;
      last_in      = last_ff;
      out_x_in     = out_x_ff;
      out_y_in     = out_y_ff;
      out_z_in     = out_z_ff;
      out_clip_in  = out_clip_ff;
      for (int a = 0; a < 3; a++) begin
         vert_in[a] = vert_ff[a];
         d_in[a]    = d_ff[a];
         acc_in[a]  = acc_ff[a];
         sum_in[a]  = sum_ff[a];
      end

      // multiplier operands: rotation word times difference by default
      mul_a      = DIFF_WEXT(rd_data_ff);
      mul_b      = d_ff[dgvb_pkg::rot_col(kd)];
      pos_sat    = dgvb_pkg::sat32(acc_ff[cnt_ff[1:0]]);
      acc_we     = 1'b0;
      acc_load   = 1'b0;
      acc_idx    = 2'd0;
      acc_addend = 64'(rd_data_ff);
      sum_idx    = 2'(cnt_ff - 5'd1);
      sum_wide   = 65'(sum_ff[sum_idx]) + 65'($signed(prod_ff[SW-1:0]));

      unique case (state_ff)
         ST_IDLE: begin
            cnt_in = 5'd0;
            if (accept && (req_action == dgvb_pkg::ACT_BLEND)) begin
               base_in    = node_base;
               vert_in[0] = req_vertex_x;
               vert_in[1] = req_vertex_y;
               vert_in[2] = req_vertex_z;
               w_in       = req_blend_weight;
               last_in    = req_last_term;
               if (in_range) begin
                  state_in = ST_NODE;
               end else if (req_last_term) begin
                  state_in = ST_FINISH;
               end
            end
         end
         ST_NODE: begin
            // center words start the sums and the differences, translation adds in
            if (data_vld) begin
               if (kd < dgvb_pkg::STEP_TRANS) begin
                  acc_we   = 1'b1;
                  acc_load = 1'b1;
                  acc_idx  = kd[1:0];
                  d_in[kd[1:0]] = DIFF_WEXT(vert_ff[kd[1:0]]) - DIFF_WEXT(rd_data_ff);
               end else if (kd < dgvb_pkg::STEP_ROT) begin
                  acc_we  = 1'b1;
                  acc_idx = 2'(kd - dgvb_pkg::STEP_TRANS);
               end
            end
            // floored rotation products fold into their row
            if (prod_vld) begin
               acc_we     = 1'b1;
               acc_idx    = dgvb_pkg::rot_row(kp);
               acc_addend = prod_shift;
            end
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == NODE_LAST) begin
               cnt_in   = 5'd0;
               state_in = ST_WEIGHT;
            end
         end
         ST_WEIGHT: begin
            // clamp each position and weigh it on the shared multiplier
            if (cnt_ff < WEIGHT_LAST) begin
               mul_a   = DIFF_WEXT(pos_sat.value);
               mul_b   = $signed(dgvb_pkg::DIFF_W'(w_ff));
               clip_in = clip_ff | pos_sat.clip;
            end
            // saturating add of the weighted position
            if (cnt_ff != 5'd0) begin
               if (sum_wide[SW] != sum_wide[SW-1]) begin
                  sum_in[sum_idx] = sum_wide[SW] ? {1'b1, {(SW-1){1'b0}}}
                                                 : {1'b0, {(SW-1){1'b1}}};
               end else begin
                  sum_in[sum_idx] = sum_wide[SW-1:0];
               end
            end
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == WEIGHT_LAST) begin
               cnt_in   = 5'd0;
               state_in = last_ff ? ST_FINISH : ST_IDLE;
            end
         end
         ST_FINISH: begin
            out_x_in     = fin_sat[0].value;
            out_y_in     = fin_sat[1].value;
            out_z_in     = fin_sat[2].value;
            out_clip_in  = clip_ff | fin_sat[0].clip | fin_sat[1].clip | fin_sat[2].clip;
            rsp_valid_in = 1'b1;
            clip_in      = 1'b0;
            for (int a = 0; a < 3; a++) begin
               sum_in[a] = '0;
            end
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // one accumulator adder
      if (acc_we) begin
         acc_in[acc_idx] = acc_load ? acc_addend : acc_ff[acc_idx] + acc_addend;
      end
      prod_in = mul_a * mul_b;
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= 5'd0;
         clip_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int a = 0; a < 3; a++) begin
            sum_ff[a] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         clip_ff      <= clip_in;
         rsp_valid_ff <= rsp_valid_in;
         for (int a = 0; a < 3; a++) begin
            sum_ff[a] <= sum_in[a];
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      base_ff     <= base_in;
      w_ff        <= w_in;
      last_ff     <= last_in;
      prod_ff     <= prod_in;
      out_x_ff    <= out_x_in;
      out_y_ff    <= out_y_in;
      out_z_ff    <= out_z_in;
      out_clip_ff <= out_clip_in;
      for (int a = 0; a < 3; a++) begin
         vert_ff[a] <= vert_in[a];
         d_ff[a]    <= d_in[a];
         acc_ff[a]  <= acc_in[a];
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_out_x   = out_x_ff;
   assign rsp_out_y   = out_y_ff;
   assign rsp_out_z   = out_z_ff;
   assign rsp_clipped = out_clip_ff;

`ifndef NO_ASSERTIONS
   // a response only follows the rounding cycle
   a_rsp_after_finish: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(state_ff == ST_FINISH))
      else $error("response without finish cycle");

   // the strobe lasts one cycle
   a_rsp_one_cycle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("response strobe longer than one cycle");

   // the node phase counter stays within its pass
   a_node_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_NODE) |-> (cnt_ff <= NODE_LAST))
      else $error("node phase counter overran");

   // sums and sticky flag start clean after a response
   a_sums_cleared: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH) |=> (sum_ff[0] == 0 && sum_ff[1] == 0 &&
                                   sum_ff[2] == 0 && !clip_ff))
      else $error("sums not cleared after response");
`endif

endmodule

`default_nettype wire
